// ----- design/fully_assoc_cache_tree_plru_core_macros.svh -----
// Assertion macros for the fully associative tree-PLRU tag store.
// Used by the datapath; expects clk and rst_n in the including scope.
`ifndef FULLY_ASSOC_CACHE_TREE_PLRU_CORE_MACROS_SVH
`define FULLY_ASSOC_CACHE_TREE_PLRU_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FATP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FATP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fatp_pkg.sv -----
// Package for the fully associative tree-PLRU tag store.
// Holds field widths, default geometry and controller/datapath signal groups.
`default_nettype none
package fatp_pkg;

  localparam int ADDR_W        = 64;
  localparam int LINE_IDX_W    = 9;
  localparam int COUNT_W       = 32;
  localparam int DEF_LINE_BYTES  = 32;
  localparam int DEF_CACHE_BYTES = 16384;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic hit_take;
    logic touch;
    logic walk_start;
    logic walk_wr;
    logic fill;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_hit;
    logic scan_miss;
    logic touch_last;
    logic walk_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- design/fatp_if.sv -----
// Valid/ready channel interfaces for the tree-PLRU tag store.
// Depends on fatp_pkg for field widths.
`default_nettype none
interface fatp_in_if;
  logic                        valid;
  logic                        ready;
  logic [fatp_pkg::ADDR_W-1:0] address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface fatp_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [fatp_pkg::LINE_IDX_W-1:0] line_index;
  logic [fatp_pkg::COUNT_W-1:0]    hit_count;
  logic [fatp_pkg::COUNT_W-1:0]    access_count;

  modport source (output valid, output hit, output line_index, output hit_count,
                  output access_count, input ready);
  modport sink   (input valid, input hit, input line_index, input hit_count,
                  input access_count, output ready);
endinterface
`default_nettype wire

// ----- design/fatp_ctrl.sv -----
// Controller state machine for the tree-PLRU tag store.
// Depends on fatp_pkg; drives datapath commands from its status.
`default_nettype none
module fatp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output fatp_pkg::cmd_t         cmd,
  input  wire fatp_pkg::status_t st
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_TOUCH,
    S_WALK_RD,
    S_WALK_WR,
    S_FILL,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        priority if (st.scan_hit) begin
          cmd.hit_take = 1'b1;
          state_nxt    = S_TOUCH;
        end else if (st.scan_miss) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_WALK_RD;
        end
      end
      S_TOUCH: begin
        cmd.touch = 1'b1;
        if (st.touch_last) state_nxt = S_EMIT;
      end
      S_WALK_RD: begin
        state_nxt = S_WALK_WR;
      end
      S_WALK_WR: begin
        cmd.walk_wr = 1'b1;
        state_nxt   = st.walk_last ? S_FILL : S_WALK_RD;
      end
      S_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/fatp_dp.sv -----
// Datapath for the tree-PLRU tag store: tag memory, tree-bit memory,
// scan and walk counters, hit/access counters and the result register.
// Depends on fatp_pkg and the assertion macro header.
`default_nettype none
`include "fully_assoc_cache_tree_plru_core_macros.svh"
module fatp_dp #(
  parameter int NUM_LINES  = fatp_pkg::DEF_CACHE_BYTES / fatp_pkg::DEF_LINE_BYTES,
  parameter int LINE_BYTES = fatp_pkg::DEF_LINE_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire fatp_pkg::cmd_t                  cmd,
  output fatp_pkg::status_t                    st,
  input  wire logic [fatp_pkg::ADDR_W-1:0]     in_address,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [fatp_pkg::LINE_IDX_W-1:0]      out_line_index,
  output logic [fatp_pkg::COUNT_W-1:0]         out_hit_count,
  output logic [fatp_pkg::COUNT_W-1:0]         out_access_count
);

  localparam int LINE_W = $clog2(NUM_LINES);
  localparam int NODE_W = LINE_W + 1;
  localparam int CNT_W  = LINE_W + 1;
  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int TAG_W  = fatp_pkg::ADDR_W - OFF_W;

  logic [TAG_W:0]  tag_mem [NUM_LINES];
  logic            tree_mem [NUM_LINES];

  logic [TAG_W-1:0]  tag_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              pend_r;
  logic [LINE_W-1:0] pidx_r;
  logic [LINE_W-1:0] line_r;
  logic [NODE_W-1:0] node_r;
  logic              hit_r;
  logic [TAG_W:0]    tag_q_r;
  logic              tree_q_r;
  logic [fatp_pkg::COUNT_W-1:0] hits_r;
  logic [fatp_pkg::COUNT_W-1:0] acc_r;
  logic              out_valid_r;

  logic [NODE_W-1:0]  parent;
  logic [NODE_W-1:0]  child;
  logic [NODE_W-1:0]  leaf_off;
  logic               issue;
  logic               tag_we;
  logic [LINE_W-1:0]  tag_wa;
  logic [TAG_W:0]     tag_wd;
  logic               tree_we;
  logic [LINE_W-1:0]  tree_wa;
  logic               tree_wd;
  logic [fatp_pkg::COUNT_W-1:0] hits_nxt;
  logic [fatp_pkg::COUNT_W-1:0] acc_nxt;

  assign leaf_off = NODE_W'(NUM_LINES - 1);
  assign parent   = (node_r - NODE_W'(1)) >> 1;
  assign child    = (node_r << 1) + NODE_W'(tree_q_r) + NODE_W'(1);
  assign issue    = cnt_r < CNT_W'(NUM_LINES);

  assign st.clr_last   = cnt_r == CNT_W'(NUM_LINES - 1);
  assign st.scan_hit   = pend_r && tag_q_r[TAG_W] && (tag_q_r[TAG_W-1:0] == tag_r);
  assign st.scan_miss  = !pend_r && !issue;
  assign st.touch_last = parent == '0;
  assign st.walk_last  = child >= leaf_off;
  assign st.out_free   = !out_valid_r || out_ready;

  always_comb begin
    tag_we = 1'b0;
    tag_wa = cnt_r[LINE_W-1:0];
    tag_wd = '0;
    priority if (cmd.clr) begin
      tag_we = 1'b1;
    end else if (cmd.fill) begin
      tag_we = 1'b1;
      tag_wa = line_r;
      tag_wd = {1'b1, tag_r};
    end
  end

  always_comb begin
    tree_we = 1'b0;
    tree_wa = node_r[LINE_W-1:0];
    tree_wd = 1'b0;
    priority if (cmd.clr) begin
      tree_we = 1'b1;
      tree_wa = cnt_r[LINE_W-1:0];
    end else if (cmd.touch) begin
      tree_we = 1'b1;
      tree_wa = parent[LINE_W-1:0];
      tree_wd = node_r[0];
    end else if (cmd.walk_wr) begin
      tree_we = 1'b1;
      tree_wd = !tree_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_q_r <= tag_mem[cnt_r[LINE_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tree_we) tree_mem[tree_wa] <= tree_wd;
    tree_q_r <= tree_mem[node_r[LINE_W-1:0]];
  end

  assign hits_nxt = hits_r + fatp_pkg::COUNT_W'(hit_r);
  assign acc_nxt  = acc_r + fatp_pkg::COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      hits_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) cnt_r <= cnt_r + CNT_W'(1);
      if (cmd.load) begin
        cnt_r  <= '0;
        pend_r <= 1'b0;
      end
      if (cmd.scan) begin
        pend_r <= issue;
        if (issue) cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        hits_r      <= hits_nxt;
        acc_r       <= acc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) tag_r <= in_address[fatp_pkg::ADDR_W-1:OFF_W];
    if (cmd.scan) pidx_r <= cnt_r[LINE_W-1:0];
    if (cmd.hit_take) begin
      hit_r  <= 1'b1;
      line_r <= pidx_r;
      node_r <= NODE_W'(pidx_r) + leaf_off;
    end
    if (cmd.walk_start) begin
      hit_r  <= 1'b0;
      node_r <= '0;
    end
    if (cmd.touch) node_r <= parent;
    if (cmd.walk_wr) begin
      node_r <= child;
      line_r <= LINE_W'(child - leaf_off);
    end
    if (cmd.emit) begin
      out_hit          <= hit_r;
      out_line_index   <= fatp_pkg::LINE_IDX_W'(line_r);
      out_hit_count    <= hits_nxt;
      out_access_count <= acc_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `FATP_ASSERT_IMP(a_tree_port_single, 1'b1, $onehot0({cmd.clr, cmd.touch, cmd.walk_wr, cmd.fill}), "tree/tag write port conflict")
  `FATP_ASSERT_IMP(a_emit_no_overwrite, cmd.emit, !out_valid_r || out_ready, "result overwritten before transaction")
  `FATP_ASSERT_NXT(a_emit_loads, cmd.emit, out_valid_r, "result register not loaded")
  `FATP_ASSERT_NXT(a_load_scan_init, cmd.load, (cnt_r == '0) && !pend_r, "scan not restarted on load")

endmodule
`default_nettype wire

// ----- design/fully_assoc_cache_tree_plru_core.sv -----
// Fully associative cache tag store with tree pseudo-LRU replacement.
// One address transaction in, one result transaction out. After reset the block
// runs a clearing pass over every line of the tag and tree memories and accepts
// no address until it ends. Each access then scans the tag memory one line per
// cycle through its registered read port: a hit ends the scan at the first
// matching line and a miss scans every line. A hit then updates the tree with
// one tree-memory write per level; a miss walks the tree with a read and a write
// per level and then fills the victim line. A finished result waits in the
// output register while the next address is taken.
// Depends on fatp_pkg, fatp_if, fatp_ctrl and fatp_dp.
`default_nettype none
module fully_assoc_cache_tree_plru_core #(
  parameter int LINE_BYTES  = fatp_pkg::DEF_LINE_BYTES,
  parameter int CACHE_BYTES = fatp_pkg::DEF_CACHE_BYTES
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fatp_in_if.sink    in_chan,
  fatp_out_if.source out_chan
);

  localparam int NUM_LINES = CACHE_BYTES / LINE_BYTES;

  fatp_pkg::cmd_t    cmd;
  fatp_pkg::status_t st;

  fatp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .st       (st)
  );

  fatp_dp #(
    .NUM_LINES  (NUM_LINES),
    .LINE_BYTES (LINE_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_address       (in_chan.address),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_hit          (out_chan.hit),
    .out_line_index   (out_chan.line_index),
    .out_hit_count    (out_chan.hit_count),
    .out_access_count (out_chan.access_count)
  );

endmodule
`default_nettype wire
